@@ rtl/core/bmd_pkg.sv @@
// Shared types, codes and constants for the bus message deframer.
package bmd_pkg;

  localparam int POS_W      = 28;
  localparam int SIZE_W     = 28;
  localparam int LEN_W      = 32;
  localparam int REM_W      = 34;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0]        ORDER_LITTLE   = 8'h6C;
  localparam logic [7:0]        ORDER_BIG      = 8'h42;
  localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 28'h800_0000;
  localparam logic [3:0]        HDR_LAST_POS   = 4'd15;
  localparam logic [REM_W-1:0]  SIZE_OVERHEAD  = 34'd12;
  localparam logic [REM_W-1:0]  ALIGN_MASK     = 34'd7;

  // Register index taken from the word address.
  localparam logic REG_MAX_MESSAGE_SIZE = 1'b0;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_HEADER    = 3'd0,
    ST_PAYLOAD   = 3'd1,
    ST_LAST      = 3'd2,
    ST_BAD_ORDER = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_DISCARD   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       burst_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    status_t          status;
    logic [POS_W-1:0] byte_position;
  } out_item_t;

  function automatic logic [LEN_W-1:0] swap32(input logic [LEN_W-1:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

@@ rtl/core/bmd_framer.sv @@
// Framing state machine: header decode, size check, payload countdown and discard to burst end.
module bmd_framer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  bmd_pkg::in_item_t         item,
  input  logic [bmd_pkg::SIZE_W-1:0] max_size,
  output bmd_pkg::out_item_t        result
);

  bmd_pkg::phase_t               phase_r, phase_nxt;
  logic [bmd_pkg::POS_W-1:0]     position_r, position_nxt;
  logic                          little_order_r, little_order_nxt;
  logic                          order_bad_r, order_bad_nxt;
  logic [bmd_pkg::LEN_W-1:0]     body_length_r, body_length_nxt;
  logic [bmd_pkg::LEN_W-1:0]     array_length_r, array_length_nxt;
  logic [bmd_pkg::REM_W-1:0]     rem_r, rem_nxt;

  logic [3:0]                    hdr_pos;
  logic [bmd_pkg::LEN_W-1:0]     arr_shift;
  logic [bmd_pkg::LEN_W-1:0]     body_val;
  logic [bmd_pkg::LEN_W-1:0]     arr_val;
  logic [bmd_pkg::REM_W-1:0]     size_sum;
  logic [bmd_pkg::REM_W-1:0]     arr_padded;
  logic [bmd_pkg::REM_W-1:0]     rem_init;
  logic                          too_large;
  logic                          hdr_fail;
  logic                          last_payload;

  assign hdr_pos   = position_r[3:0];
  // The last array byte arrives with the 16th header byte itself.
  assign arr_shift = {array_length_r[bmd_pkg::LEN_W-9:0], item.data_byte};
  assign body_val  = little_order_r ? bmd_pkg::swap32(body_length_r) : body_length_r;
  assign arr_val   = little_order_r ? bmd_pkg::swap32(arr_shift) : arr_shift;

  assign size_sum   = {2'b00, body_val} + {2'b00, arr_val} + bmd_pkg::SIZE_OVERHEAD;
  assign too_large  = size_sum > {{(bmd_pkg::REM_W-bmd_pkg::SIZE_W){1'b0}}, max_size};
  assign hdr_fail   = order_bad_r || too_large;
  assign arr_padded = ({2'b00, arr_val} + bmd_pkg::ALIGN_MASK) & ~bmd_pkg::ALIGN_MASK;
  assign rem_init   = arr_padded + {2'b00, body_val};

  assign last_payload = (rem_r == {{(bmd_pkg::REM_W-1){1'b0}}, 1'b1});

  // Next state.
  always_comb begin
    phase_nxt        = phase_r;
    position_nxt     = position_r;
    little_order_nxt = little_order_r;
    order_bad_nxt    = order_bad_r;
    body_length_nxt  = body_length_r;
    array_length_nxt = array_length_r;
    rem_nxt          = rem_r;
    if (accept) begin
      case (phase_r)
        bmd_pkg::PH_HEADER: begin
          if (hdr_pos == 4'd0) begin
            little_order_nxt = (item.data_byte == bmd_pkg::ORDER_LITTLE);
            order_bad_nxt    = !((item.data_byte == bmd_pkg::ORDER_LITTLE) ||
                                 (item.data_byte == bmd_pkg::ORDER_BIG));
          end
          if (hdr_pos inside {[4'd4:4'd7]}) begin
            body_length_nxt = {body_length_r[bmd_pkg::LEN_W-9:0], item.data_byte};
          end
          if (hdr_pos inside {[4'd12:4'd15]}) begin
            array_length_nxt = arr_shift;
          end
          position_nxt = {{(bmd_pkg::POS_W-5){1'b0}}, {1'b0, hdr_pos} + 5'd1};
          if (hdr_pos == bmd_pkg::HDR_LAST_POS) begin
            if (hdr_fail) begin
              if (item.burst_end) begin
                phase_nxt    = bmd_pkg::PH_HEADER;
                position_nxt = '0;
              end else begin
                phase_nxt = bmd_pkg::PH_DISCARD;
              end
            end else begin
              rem_nxt = rem_init;
              if (rem_init == '0) begin
                phase_nxt    = bmd_pkg::PH_HEADER;
                position_nxt = '0;
              end else begin
                phase_nxt = bmd_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        bmd_pkg::PH_PAYLOAD: begin
          rem_nxt = rem_r - {{(bmd_pkg::REM_W-1){1'b0}}, 1'b1};
          if (last_payload) begin
            phase_nxt    = bmd_pkg::PH_HEADER;
            position_nxt = '0;
          end else if (position_r != '1) begin
            position_nxt = position_r + {{(bmd_pkg::POS_W-1){1'b0}}, 1'b1};
          end
        end
        bmd_pkg::PH_DISCARD: begin
          if (item.burst_end) begin
            phase_nxt    = bmd_pkg::PH_HEADER;
            position_nxt = '0;
          end
        end
        default: begin
          phase_nxt    = bmd_pkg::PH_HEADER;
          position_nxt = '0;
        end
      endcase
    end
  end

  // Result for the byte being accepted.
  always_comb begin
    result.out_byte      = item.data_byte;
    result.status        = bmd_pkg::ST_HEADER;
    result.byte_position = position_r;
    case (phase_r)
      bmd_pkg::PH_HEADER: begin
        if (hdr_pos == bmd_pkg::HDR_LAST_POS) begin
          if (order_bad_r) begin
            result.status = bmd_pkg::ST_BAD_ORDER;
          end else if (too_large) begin
            result.status = bmd_pkg::ST_TOO_LARGE;
          end else if (rem_init == '0) begin
            result.status = bmd_pkg::ST_LAST;
          end
        end
      end
      bmd_pkg::PH_PAYLOAD: begin
        result.status = last_payload ? bmd_pkg::ST_LAST : bmd_pkg::ST_PAYLOAD;
      end
      bmd_pkg::PH_DISCARD: begin
        result.status        = bmd_pkg::ST_DISCARD;
        result.byte_position = '0;
      end
      default: begin
        result.status = bmd_pkg::ST_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= bmd_pkg::PH_HEADER;
      position_r     <= '0;
      little_order_r <= 1'b0;
      order_bad_r    <= 1'b0;
      body_length_r  <= '0;
      array_length_r <= '0;
      rem_r          <= '0;
    end else begin
      phase_r        <= phase_nxt;
      position_r     <= position_nxt;
      little_order_r <= little_order_nxt;
      order_bad_r    <= order_bad_nxt;
      body_length_r  <= body_length_nxt;
      array_length_r <= array_length_nxt;
      rem_r          <= rem_nxt;
    end
  end

  a_header_pos_small: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == bmd_pkg::PH_HEADER) |-> (position_r < 28'd16))
    else $error("header position out of range");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == bmd_pkg::PH_PAYLOAD) |-> (rem_r != '0))
    else $error("payload phase with nothing remaining");

  a_discard_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (phase_r == bmd_pkg::PH_DISCARD) && item.burst_end)
    |=> ((phase_r == bmd_pkg::PH_HEADER) && (position_r == '0)))
    else $error("discard did not end at burst end");

endmodule

@@ rtl/core/bus_message_deframer_core.sv @@
// Top level of the bus message deframer: config register, framer and output buffer.
//
//   channel  direction  handshake                payload
//   in_      input      in_valid / in_ready      bmd_pkg::in_item_t  (data_byte, burst_end)
//   out_     output     out_valid / out_ready    bmd_pkg::out_item_t (out_byte, status, position)
//   config   input      psel/penable/pwrite      max_message_size at byte address 0
//
// One byte per clock is accepted while in_ready is high, and each yields one registered result.
// The 16th header byte carries the size add and compare, which sets the cycle time.
// A two-entry output buffer lets a byte be taken while one result waits.
// in_ready drops only when both output entries are full.
// Reset is synchronous and returns the framer to the start of a header.
module bus_message_deframer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bmd_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bmd_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bmd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bmd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bmd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic [bmd_pkg::SIZE_W-1:0] max_size_r;
  logic                       cfg_write;
  logic                       in_accept;
  logic                       out_pop;
  bmd_pkg::out_item_t         result;
  bmd_pkg::out_item_t         out_r, out_nxt;
  bmd_pkg::out_item_t         skid_r, skid_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       skid_valid_r, skid_valid_nxt;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == bmd_pkg::REG_MAX_MESSAGE_SIZE);
  assign prdata    = (paddr[2] == bmd_pkg::REG_MAX_MESSAGE_SIZE) ?
                     {{(bmd_pkg::CFG_DATA_W-bmd_pkg::SIZE_W){1'b0}}, max_size_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= bmd_pkg::MAX_SIZE_RESET;
    end else if (cfg_write) begin
      max_size_r <= pwdata[bmd_pkg::SIZE_W-1:0];
    end
  end

  assign in_ready  = !skid_valid_r;
  assign in_accept = in_valid && in_ready;
  assign out_pop   = out_valid_r && out_ready;

  bmd_framer u_framer (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .item     (in_data),
    .max_size (max_size_r),
    .result   (result)
  );

  // A push never coincides with a full skid entry, since in_ready is low then.
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = result;
        out_valid_nxt = in_accept;
      end
    end else if (in_accept) begin
      if (out_valid_r) begin
        skid_nxt       = result;
        skid_valid_nxt = 1'b1;
      end else begin
        out_nxt       = result;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("transaction lost while output stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted byte produced no result");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for bus_message_deframer_core: random framed byte streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  logic                           clk      = 1'b0;
  logic                           rst_n    = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  bmd_pkg::in_item_t              in_data  = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  bmd_pkg::out_item_t             out_data;
  logic                           psel     = 1'b0;
  logic                           penable  = 1'b0;
  logic                           pwrite   = 1'b0;
  logic [bmd_pkg::CFG_ADDR_W-1:0] paddr    = '0;
  logic [bmd_pkg::CFG_DATA_W-1:0] pwdata   = '0;
  logic [bmd_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  bmd_pkg::in_item_t  link_q[$];
  bmd_pkg::out_item_t framed_q[$];
  int                 err_count   = 0;
  int                 stall_count = 0;
  int unsigned        idle_pct    = 26;

  // Mirror of the deframer state.
  bmd_pkg::phase_t            fr_phase     = bmd_pkg::PH_HEADER;
  logic [bmd_pkg::POS_W-1:0]  fr_pos       = '0;
  logic                       fr_little    = 1'b0;
  logic                       fr_bad_order = 1'b0;
  logic [bmd_pkg::LEN_W-1:0]  fr_body      = '0;
  logic [bmd_pkg::LEN_W-1:0]  fr_array     = '0;
  logic [bmd_pkg::REM_W-1:0]  fr_left      = '0;
  logic [bmd_pkg::SIZE_W-1:0] size_limit   = bmd_pkg::MAX_SIZE_RESET;

  always #2 clk = ~clk;

  bus_message_deframer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  function automatic logic [bmd_pkg::REM_W-1:0] widen(input logic [bmd_pkg::LEN_W-1:0] v);
    return {{(bmd_pkg::REM_W-bmd_pkg::LEN_W){1'b0}}, v};
  endfunction

  function automatic logic [bmd_pkg::LEN_W-1:0] limit_len();
    return {{(bmd_pkg::LEN_W-bmd_pkg::SIZE_W){1'b0}}, size_limit};
  endfunction

  function automatic bmd_pkg::out_item_t frame_byte(input bmd_pkg::in_item_t it);
    bmd_pkg::out_item_t        r;
    logic [3:0]                p;
    logic [bmd_pkg::LEN_W-1:0] body;
    logic [bmd_pkg::LEN_W-1:0] arr;
    logic [bmd_pkg::REM_W-1:0] sum;
    logic [bmd_pkg::REM_W-1:0] padded;
    r.out_byte      = it.data_byte;
    r.status        = bmd_pkg::ST_HEADER;
    r.byte_position = fr_pos;
    case (fr_phase)
      bmd_pkg::PH_DISCARD: begin
        r.status        = bmd_pkg::ST_DISCARD;
        r.byte_position = '0;
        if (it.burst_end) begin
          fr_phase = bmd_pkg::PH_HEADER;
          fr_pos   = '0;
        end
      end
      bmd_pkg::PH_PAYLOAD: begin
        fr_left = fr_left - {{(bmd_pkg::REM_W-1){1'b0}}, 1'b1};
        if (fr_left == '0) begin
          r.status = bmd_pkg::ST_LAST;
          fr_phase = bmd_pkg::PH_HEADER;
          fr_pos   = '0;
        end else begin
          r.status = bmd_pkg::ST_PAYLOAD;
          if (fr_pos != '1) fr_pos = fr_pos + {{(bmd_pkg::POS_W-1){1'b0}}, 1'b1};
        end
      end
      default: begin
        p = fr_pos[3:0];
        if (p == 4'd0) begin
          fr_little    = (it.data_byte == bmd_pkg::ORDER_LITTLE);
          fr_bad_order = !(fr_little || it.data_byte == bmd_pkg::ORDER_BIG);
        end
        if (p >= 4'd4 && p <= 4'd7) fr_body = {fr_body[23:0], it.data_byte};
        if (p >= 4'd12) fr_array = {fr_array[23:0], it.data_byte};
        fr_pos = {{(bmd_pkg::POS_W-5){1'b0}}, {1'b0, p} + 5'd1};
        if (p == bmd_pkg::HDR_LAST_POS) begin
          body = fr_body;
          arr  = fr_array;
          if (fr_little) begin
            body = {fr_body[7:0], fr_body[15:8], fr_body[23:16], fr_body[31:24]};
            arr  = {fr_array[7:0], fr_array[15:8], fr_array[23:16], fr_array[31:24]};
          end
          // The size sum is formed on 34 bits so it cannot wrap.
          sum = widen(body) + widen(arr) + bmd_pkg::SIZE_OVERHEAD;
          if (fr_bad_order || sum > widen(limit_len())) begin
            r.status = fr_bad_order ? bmd_pkg::ST_BAD_ORDER : bmd_pkg::ST_TOO_LARGE;
            if (it.burst_end) begin
              fr_phase = bmd_pkg::PH_HEADER;
              fr_pos   = '0;
            end else begin
              fr_phase = bmd_pkg::PH_DISCARD;
            end
          end else begin
            padded  = (widen(arr) + bmd_pkg::ALIGN_MASK) & ~bmd_pkg::ALIGN_MASK;
            fr_left = padded + widen(body);
            if (fr_left == '0) begin
              r.status = bmd_pkg::ST_LAST;
              fr_phase = bmd_pkg::PH_HEADER;
              fr_pos   = '0;
            end else begin
              fr_phase = bmd_pkg::PH_PAYLOAD;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic push_link(input logic [7:0] b, input logic be);
    bmd_pkg::in_item_t it;
    it.data_byte = b;
    it.burst_end = be;
    link_q.push_back(it);
  endtask

  // hdr_end sets burst_end on the 16th header byte: 0 or 1, or 2 for random.
  task automatic push_frame(input logic [7:0] order, input logic [bmd_pkg::LEN_W-1:0] body,
                            input logic [bmd_pkg::LEN_W-1:0] arr, input int hdr_end);
    logic                      little;
    logic                      bad;
    logic [bmd_pkg::REM_W-1:0] sum;
    logic [bmd_pkg::REM_W-1:0] payload;
    logic [7:0]                b;
    logic                      be;
    int                        k;
    little = (order == bmd_pkg::ORDER_LITTLE);
    bad    = !little && order != bmd_pkg::ORDER_BIG;
    sum    = widen(body) + widen(arr) + bmd_pkg::SIZE_OVERHEAD;
    be     = 1'b0;
    for (int i = 0; i < 16; i++) begin
      b = 8'($urandom);
      if (i == 0) begin
        b = order;
      end else if (i >= 4 && i <= 7) begin
        b = little ? body[8*(i-4) +: 8] : body[8*(7-i) +: 8];
      end else if (i >= 12) begin
        b = little ? arr[8*(i-12) +: 8] : arr[8*(15-i) +: 8];
      end
      be = ($urandom_range(99) < 20);
      if (i == 15 && hdr_end != 2) be = hdr_end[0];
      push_link(b, be);
    end
    if (bad || sum > widen(limit_len())) begin
      // A rejected header is followed by a short run that ends its burst.
      if (!be) begin
        k = int'($urandom_range(4));
        repeat (k) push_link(8'($urandom), 1'b0);
        push_link(8'($urandom), 1'b1);
      end
    end else begin
      payload = ((widen(arr) + bmd_pkg::ALIGN_MASK) & ~bmd_pkg::ALIGN_MASK) + widen(body);
      for (int n = 0; n < int'(payload); n++) begin
        if (n == int'(payload) - 1) be = ($urandom_range(1) == 1);
        else be = ($urandom_range(99) < 20);
        push_link(8'($urandom), be);
      end
    end
  endtask

  task automatic fill_random(input int count);
    int                        stop;
    int                        avail;
    int                        pick;
    logic [bmd_pkg::LEN_W-1:0] body;
    logic [bmd_pkg::LEN_W-1:0] arr;
    logic [7:0]                order;
    stop = link_q.size() + count;
    while (link_q.size() < stop) begin
      pick  = int'($urandom_range(99));
      order = ($urandom_range(1) == 1) ? bmd_pkg::ORDER_LITTLE : bmd_pkg::ORDER_BIG;
      avail = (size_limit > 12) ? int'(size_limit) - 12 : 0;
      if (avail > 40) avail = 40;
      body = $urandom_range(avail);
      arr  = $urandom_range(avail - int'(body));
      if (pick < 10) begin
        body = '0;
        arr  = '0;
      end else if (pick < 22 && size_limit >= 12 && size_limit <= 212) begin
        // Sum lands exactly on the limit.
        body = $urandom_range(int'(size_limit) - 12);
        arr  = limit_len() - 32'd12 - body;
      end else if (pick < 30) begin
        body = '1;
        arr  = '1;
      end else if (pick < 38) begin
        // Sum lands one above the limit.
        if (size_limit >= 11) begin
          body = $urandom_range(int'(size_limit) - 11);
          arr  = limit_len() - 32'd11 - body;
        end else begin
          body = '0;
          arr  = '0;
        end
      end else if (pick < 44) begin
        body = $urandom;
        arr  = {1'b1, 31'($urandom)};
      end else if (pick < 54) begin
        do order = 8'($urandom);
        while (order == bmd_pkg::ORDER_LITTLE || order == bmd_pkg::ORDER_BIG);
      end
      push_frame(order, body, arr, 2);
    end
  endtask

  task automatic await_idle();
    while (link_q.size() != 0 || in_valid || framed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_size(input logic [bmd_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bmd_pkg::REG_MAX_MESSAGE_SIZE, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_limit = value[bmd_pkg::SIZE_W-1:0];
  endtask

  // Driver: one byte transaction at a time from link_q, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) framed_q.push_back(frame_byte(in_data));
      if (!in_valid || in_ready) begin
        if (link_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data  <= link_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transaction is checked against the oldest prediction.
  always @(posedge clk) begin : result_check
    bmd_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (framed_q.size() == 0) begin
          $error("unexpected result: out_byte %0h", out_data.out_byte);
          err_count++;
        end else begin
          want = framed_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_data.out_byte);
            err_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            err_count++;
          end
          if (out_data.byte_position !== want.byte_position) begin
            $error("byte_position: expected %0d, got %0d",
                   want.byte_position, out_data.byte_position);
            err_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      stall_count <= 0;
    end else if (stall_count >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    logic [bmd_pkg::CFG_DATA_W-1:0] size_plan[5];
    int                             plan_bytes[5];
    size_plan  = '{32'hF000_0010, 32'd100, 32'd5, 32'hFFFF_FFFF, 32'h0800_0000};
    plan_bytes = '{100, 150, 40, 150, 150};
    // Empty message, then an oversized header whose sum would wrap on 32 bits,
    // ending its burst on the 16th byte.
    push_frame(bmd_pkg::ORDER_BIG, '0, '0, 1);
    push_frame(bmd_pkg::ORDER_LITTLE, '1, '1, 1);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    fill_random(120);
    foreach (size_plan[i]) begin
      await_idle();
      write_max_size(size_plan[i]);
      idle_pct = (i == 1) ? 0 : 26;
      fill_random(plan_bytes[i]);
    end
    await_idle();
    if (err_count == 0 && framed_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bmd_pkg.sv
rtl/core/bmd_framer.sv
rtl/core/bus_message_deframer_core.sv
test/tb_top.sv
